// ===== design/double_fused_multiply_add_core_macros.svh =====
// Assertion helpers for the fused multiply-add core.
// Each use names a clock and an active-low reset signal in scope: clk_i, rst_ni.
`ifndef DOUBLE_FUSED_MULTIPLY_ADD_CORE_MACROS_SVH
`define DOUBLE_FUSED_MULTIPLY_ADD_CORE_MACROS_SVH

// Same-cycle implication.
`define DFMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fma core check failed");

// Next-cycle implication.
`define DFMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fma core check failed");

`endif

// ===== design/dfma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfma_pkg
// Types, constants and unpack helper shared by the fused multiply-add core.
// ----------------------------------------------------------------------------
package dfma_pkg;

  localparam logic [1:0] RM_RNE = 2'd0;
  localparam logic [1:0] RM_RTZ = 2'd1;
  localparam logic [1:0] RM_RUP = 2'd2;
  localparam logic [1:0] RM_RDN = 2'd3;

  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
  localparam logic [62:0] INF_MAG   = 63'h7FF0_0000_0000_0000;
  localparam logic [62:0] MAX_MAG   = 63'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DEF_NAN   = 64'h7FF8_0000_0000_0000;

  // flag vector bit positions
  localparam int FL_INV = 3;
  localparam int FL_OVF = 2;
  localparam int FL_UNF = 1;
  localparam int FL_INX = 0;

  typedef logic signed [13:0] exp_t;

  typedef struct packed {
    logic [52:0] m;
    exp_t        e;
  } unp_t;

  // side band carried down the pipe: early result for special operands
  typedef struct packed {
    logic        spec;
    logic [63:0] res;
    logic [3:0]  fl;
    logic [1:0]  mode;
  } side_t;

  // finite nonzero value = m * 2^(e-52) with m[52] set
  function automatic unp_t unpack(logic [63:0] u);
    unp_t       r;
    logic [5:0] lz;
    logic       found;
    lz    = '0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found) begin
        if (u[i]) found = 1'b1;
        else lz = lz + 6'd1;
      end
    end
    if (u[62:52] == 11'd0) begin
      r.m = 53'({1'b0, u[51:0]} << (lz + 6'd1));
      r.e = -14'sd1023 - $signed({8'b0, lz});
    end else begin
      r.m = {1'b1, u[51:0]};
      r.e = $signed({3'b0, u[62:52]}) - 14'sd1023;
    end
    return r;
  endfunction

endpackage

// ===== design/dfma_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfma channel interfaces
// Operand request, result and rounding-mode write channels.
// ----------------------------------------------------------------------------
interface dfma_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] mult_a;
  logic [63:0] mult_b;
  logic [63:0] addend;
  modport source (output valid, mult_a, mult_b, addend, input ready);
  modport sink   (input valid, mult_a, mult_b, addend, output ready);
endinterface

interface dfma_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] sum_bits;
  logic        flag_invalid;
  logic        flag_overflow;
  logic        flag_underflow;
  logic        flag_inexact;
  modport source (output valid, sum_bits, flag_invalid, flag_overflow, flag_underflow,
                  flag_inexact, input ready);
  modport sink   (input valid, sum_bits, flag_invalid, flag_overflow, flag_underflow,
                  flag_inexact, output ready);
endinterface

interface dfma_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] rounding_mode;
  modport source (output valid, rounding_mode, input ready);
  modport sink   (input valid, rounding_mode, output ready);
endinterface

// ===== design/double_fused_multiply_add_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_fused_multiply_add_core
// Pipelined binary64 fused multiply-add, x*y+z with a single rounding.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload                                      | Handshake
// req_i   | in  | mult_a, mult_b, addend (64b each)            | valid/ready
// res_o   | out | sum_bits (64b), four exception flags         | valid/ready
// cfg_i   | in  | rounding_mode (2b)                           | valid/ready
//
// One request enters per cycle while the result is not held.
// Depth is set by the 53x53 product (split into four partial products over two
// stages), the 128-bit alignment, add, leading-one search and normalize shift.
// Reset clears the valid bits and the rounding mode; payload registers do not reset.
// When the result is held the whole pipe holds, and req ready drops with it.
// cfg_i is always ready.
// ----------------------------------------------------------------------------
`include "double_fused_multiply_add_core_macros.svh"

module double_fused_multiply_add_core
  import dfma_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  dfma_req_if.sink      req_i,
  dfma_res_if.source    res_o,
  dfma_cfg_if.sink      cfg_i
);

  // Advance all stages unless the finished result waits.
  logic adv;
  logic [1:0] mode_q;
  logic [9:1] v_q;

  assign adv         = !v_q[9] || res_o.ready;
  assign req_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RM_RNE;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.rounding_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[8:1], req_i.valid};
    end
  end

  // ---------------- stage 1: classify, unpack ----------------
  logic [63:0] a, b, c;
  logic a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, a_zero, b_zero, c_zero;
  logic a_snan, b_snan, c_snan, sp_c;
  side_t sd1_d;
  unp_t  ua, ub, uc;

  assign a = req_i.mult_a;
  assign b = req_i.mult_b;
  assign c = req_i.addend;
  assign a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
  assign b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
  assign c_nan  = (c[62:52] == 11'h7FF) && (c[51:0] != '0);
  assign a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == '0);
  assign b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
  assign c_inf  = (c[62:52] == 11'h7FF) && (c[51:0] == '0);
  assign a_zero = (a[62:0] == '0);
  assign b_zero = (b[62:0] == '0);
  assign c_zero = (c[62:0] == '0);
  assign a_snan = a_nan && !a[51];
  assign b_snan = b_nan && !b[51];
  assign c_snan = c_nan && !c[51];
  assign sp_c   = a[63] ^ b[63];
  assign ua = unpack(a);
  assign ub = unpack(b);
  assign uc = unpack(c);

  always_comb begin
    sd1_d      = '0;
    sd1_d.mode = mode_q;
    sd1_d.spec = 1'b1;
    if (a_nan || b_nan || c_nan) begin
      sd1_d.fl[FL_INV] = a_snan || b_snan || c_snan;
      sd1_d.res = (a_nan ? a : (b_nan ? b : c)) | QUIET_BIT;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      sd1_d.res = DEF_NAN;
      sd1_d.fl[FL_INV] = 1'b1;
    end else if (a_inf || b_inf) begin
      if (c_inf && (c[63] != sp_c)) begin
        sd1_d.res = DEF_NAN;
        sd1_d.fl[FL_INV] = 1'b1;
      end else begin
        sd1_d.res = {sp_c, INF_MAG};
      end
    end else if (c_inf) begin
      sd1_d.res = c;
    end else if (a_zero || b_zero) begin
      // zero product: addend passes; opposite-signed zeros give the mode's zero
      if (!c_zero || (c[63] == sp_c)) sd1_d.res = c;
      else sd1_d.res = (mode_q == RM_RDN) ? SIGN_BIT : 64'd0;
    end else begin
      sd1_d.spec = 1'b0;
    end
  end

  side_t sd1_q;
  logic [52:0] mx1_q, my1_q, mz1_q;
  exp_t ex1_q, ey1_q, ez1_q;
  logic sp1_q, sz1_q, zz1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd1_q <= sd1_d;
      mx1_q <= ua.m;
      my1_q <= ub.m;
      mz1_q <= c_zero ? 53'd0 : uc.m;
      ex1_q <= ua.e;
      ey1_q <= ub.e;
      ez1_q <= c_zero ? 14'sd0 : uc.e;
      sp1_q <= sp_c;
      sz1_q <= c[63];
      zz1_q <= c_zero;
    end
  end

  // ---------------- stage 2: partial products ----------------
  side_t sd2_q;
  logic [51:0] pp_hh_q;
  logic [52:0] pp_hl_q, pp_lh_q;
  logic [53:0] pp_ll_q;
  logic [52:0] mz2_q;
  exp_t ep2_q, ez2_q;
  logic sp2_q, sz2_q, zz2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd2_q   <= sd1_q;
      pp_hh_q <= mx1_q[52:27] * my1_q[52:27];
      pp_hl_q <= mx1_q[52:27] * my1_q[26:0];
      pp_lh_q <= mx1_q[26:0] * my1_q[52:27];
      pp_ll_q <= mx1_q[26:0] * my1_q[26:0];
      mz2_q   <= mz1_q;
      ep2_q   <= ex1_q + ey1_q;
      ez2_q   <= ez1_q;
      sp2_q   <= sp1_q;
      sz2_q   <= sz1_q;
      zz2_q   <= zz1_q;
    end
  end

  // ---------------- stage 3: sum product, frame leading bit at 120 ----------------
  logic [105:0] prod;
  logic [127:0] w0;
  assign prod = {pp_hh_q, 54'd0} + {26'd0, pp_hl_q, 27'd0} + {26'd0, pp_lh_q, 27'd0}
              + {52'd0, pp_ll_q};
  assign w0   = {6'd0, prod, 16'd0};

  side_t sd3_q;
  logic [127:0] w3_q;
  logic [52:0] mz3_q;
  exp_t ep3_q, ez3_q;
  logic sp3_q, sz3_q, zz3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd3_q <= sd2_q;
      w3_q  <= prod[105] ? (w0 >> 1) : w0;
      ep3_q <= prod[105] ? ep2_q + 14'sd1 : ep2_q;
      mz3_q <= mz2_q;
      ez3_q <= ez2_q;
      sp3_q <= sp2_q;
      sz3_q <= sz2_q;
      zz3_q <= zz2_q;
    end
  end

  // ---------------- stage 4: compare, swap, exact cancellation ----------------
  logic [127:0] zf;
  logic cancel, pbig;
  side_t sd4_d;
  assign zf     = {7'd0, mz3_q, 68'd0};
  assign cancel = !zz3_q && (ep3_q == ez3_q) && (w3_q == zf) && (sp3_q != sz3_q);
  assign pbig   = zz3_q || (ep3_q > ez3_q) || ((ep3_q == ez3_q) && (w3_q > zf));

  always_comb begin
    sd4_d = sd3_q;
    if (!sd3_q.spec && cancel) begin
      sd4_d.spec = 1'b1;
      sd4_d.fl   = '0;
      sd4_d.res  = (sd3_q.mode == RM_RDN) ? SIGN_BIT : 64'd0;
    end
  end

  side_t sd4_q;
  logic [127:0] a4_q, b4_q;
  exp_t ea4_q, d4_q;
  logic rs4_q, sub4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd4_q  <= sd4_d;
      sub4_q <= !zz3_q && (sp3_q != sz3_q);
      if (zz3_q) begin
        a4_q <= w3_q; b4_q <= '0; ea4_q <= ep3_q; rs4_q <= sp3_q; d4_q <= 14'sd0;
      end else if (pbig) begin
        a4_q <= w3_q; b4_q <= zf; ea4_q <= ep3_q; rs4_q <= sp3_q; d4_q <= ep3_q - ez3_q;
      end else begin
        a4_q <= zf; b4_q <= w3_q; ea4_q <= ez3_q; rs4_q <= sz3_q; d4_q <= ez3_q - ep3_q;
      end
    end
  end

  // ---------------- stage 5: align smaller operand with sticky ----------------
  logic d_big;
  logic [7:0] d_sh;
  assign d_big = (d4_q >= 14'sd128);
  assign d_sh  = {1'b0, d4_q[6:0]};

  side_t sd5_q;
  logic [127:0] a5_q, b5_q;
  exp_t ea5_q;
  logic rs5_q, sub5_q, st5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd5_q  <= sd4_q;
      a5_q   <= a4_q;
      ea5_q  <= ea4_q;
      rs5_q  <= rs4_q;
      sub5_q <= sub4_q;
      if (d_big) begin
        b5_q  <= '0;
        st5_q <= |b4_q;
      end else begin
        b5_q  <= b4_q >> d_sh;
        st5_q <= |(b4_q << (8'd128 - d_sh));
      end
    end
  end

  // ---------------- stage 6: add or subtract ----------------
  side_t sd6_q;
  logic [127:0] r6_q;
  exp_t ea6_q;
  logic rs6_q, st6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd6_q <= sd5_q;
      r6_q  <= sub5_q ? (a5_q - b5_q - {127'd0, st5_q}) : (a5_q + b5_q);
      ea6_q <= ea5_q;
      rs6_q <= rs5_q;
      st6_q <= st5_q;
    end
  end

  // ---------------- stage 7: leading one, tininess, shift amount ----------------
  logic [6:0] hb;
  exp_t hbs, lpos_n, lpos_s;
  always_comb begin
    hb = '0;
    for (int i = 0; i < 128; i++) begin
      if (r6_q[i]) hb = 7'(i);
    end
  end
  assign hbs    = $signed({7'd0, hb});
  assign lpos_n = hbs - 14'sd52;
  assign lpos_s = -14'sd954 - ea6_q;

  side_t sd7_q;
  logic [127:0] r7_q;
  exp_t ea7_q, lpos7_q;
  logic rs7_q, st7_q, tiny7_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd7_q   <= sd6_q;
      r7_q    <= r6_q;
      ea7_q   <= ea6_q;
      rs7_q   <= rs6_q;
      st7_q   <= st6_q;
      tiny7_q <= (ea6_q - 14'sd120 + hbs) < -14'sd1022;
      lpos7_q <= (lpos_s > lpos_n) ? lpos_s : lpos_n;
    end
  end

  // ---------------- stage 8: normalize to 53 bits plus guard ----------------
  exp_t sh_r, sh_l;
  logic sh_big;
  logic [7:0] sh8;
  logic [127:0] rr;
  logic [52:0] m_n;
  logic g_n, st_n;

  assign sh_r   = lpos7_q - 14'sd1;
  assign sh_l   = -lpos7_q;
  assign sh_big = (sh_r >= 14'sd128);
  assign sh8    = {1'b0, sh_r[6:0]};

  always_comb begin
    rr   = r7_q >> sh8;
    st_n = st7_q;
    g_n  = 1'b0;
    m_n  = '0;
    if (lpos7_q > 14'sd0) begin
      if (sh_big) begin
        st_n = st7_q || (|r7_q);
      end else begin
        st_n = st7_q || (|(r7_q << (8'd128 - sh8)));
        g_n  = rr[0];
        m_n  = rr[53:1];
      end
    end else begin
      m_n = r7_q[52:0] << sh_l[5:0];
    end
  end

  side_t sd8_q;
  logic [52:0] m8_q;
  exp_t q8_q;
  logic rs8_q, st8_q, g8_q, tiny8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd8_q   <= sd7_q;
      m8_q    <= m_n;
      q8_q    <= lpos7_q + ea7_q - 14'sd120;
      rs8_q   <= rs7_q;
      st8_q   <= st_n;
      g8_q    <= g_n;
      tiny8_q <= tiny7_q;
    end
  end

  // ---------------- stage 9: round, pack, select ----------------
  logic inx, up, to_inf, ovf;
  logic [53:0] m2;
  logic [52:0] mr;
  exp_t qr, field;
  logic [63:0] res_n;
  logic [3:0] fl_n;

  assign inx = g8_q || st8_q;
  always_comb begin
    case (sd8_q.mode)
      RM_RNE:  up = g8_q && (st8_q || m8_q[0]);
      RM_RUP:  up = inx && !rs8_q;
      RM_RDN:  up = inx && rs8_q;
      default: up = 1'b0;
    endcase
  end
  assign m2     = {1'b0, m8_q} + {53'd0, up};
  assign mr     = m2[53] ? m2[53:1] : m2[52:0];
  assign qr     = m2[53] ? q8_q + 14'sd1 : q8_q;
  assign field  = mr[52] ? qr + 14'sd1075 : 14'sd0;
  assign ovf    = (field >= 14'sd2047);
  assign to_inf = (sd8_q.mode == RM_RNE) || ((sd8_q.mode == RM_RUP) && !rs8_q)
               || ((sd8_q.mode == RM_RDN) && rs8_q);

  always_comb begin
    fl_n = '0;
    if (sd8_q.spec) begin
      res_n = sd8_q.res;
      fl_n  = sd8_q.fl;
    end else if (ovf) begin
      res_n = {rs8_q, to_inf ? INF_MAG : MAX_MAG};
      fl_n[FL_OVF] = 1'b1;
      fl_n[FL_INX] = 1'b1;
      fl_n[FL_UNF] = tiny8_q;
    end else begin
      res_n = {rs8_q, field[10:0], mr[51:0]};
      fl_n[FL_INX] = inx;
      fl_n[FL_UNF] = inx && tiny8_q;
    end
  end

  logic [63:0] res9_q;
  logic [3:0]  fl9_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res9_q <= res_n;
      fl9_q  <= fl_n;
    end
  end

  assign res_o.valid          = v_q[9];
  assign res_o.sum_bits       = res9_q;
  assign res_o.flag_invalid   = fl9_q[FL_INV];
  assign res_o.flag_overflow  = fl9_q[FL_OVF];
  assign res_o.flag_underflow = fl9_q[FL_UNF];
  assign res_o.flag_inexact   = fl9_q[FL_INX];

  // A held result must block new requests.
  `DFMA_ASSERT_NOW(a_stall_blocks, res_o.valid && !res_o.ready, !req_i.ready)
  // Overflow and underflow never come without inexact.
  `DFMA_ASSERT_NOW(a_ovf_inx, res_o.valid && res_o.flag_overflow, res_o.flag_inexact)
  `DFMA_ASSERT_NOW(a_unf_inx, res_o.valid && res_o.flag_underflow, res_o.flag_inexact)
  // A request taken while the pipe advances shows up in the first stage.
  `DFMA_ASSERT_NEXT(a_enter, req_i.valid && req_i.ready, v_q[1])

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary64 fused multiply-add core. A table of
// hand-picked operand triples runs first, then several phases of random
// triples, one rounding mode per phase. Every result is checked field by field
// against the fixed value of its table row or a bit-true FMA model held in this file.
// ----------------------------------------------------------------------------
module tb_top;
  import dfma_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int DRAIN_CYC  = 20;    // pipe is nine deep; leave margin
  localparam int STALL_MAX  = 5000;  // cycles without any handshake
  localparam int ITEMS_PHASE = 250;

  typedef struct packed {
    logic [63:0] sum;
    logic        inv;
    logic        ovf;
    logic        unf;
    logic        inx;
  } fma_res_t;

  typedef struct {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    bit          fixed;
    fma_res_t    want;
  } vec_t;

  logic clk_i;
  logic rst_ni;

  dfma_req_if req ();
  dfma_res_if res ();
  dfma_cfg_if cfg ();

  double_fused_multiply_add_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  // Expected results in request order, and the one queued for the next request.
  fma_res_t   sum_q[$];
  fma_res_t   next_sum;
  logic [1:0] cur_mode;
  int         mismatches;
  int         sent;

  // Output snapshots taken at the falling edge, used at the next rising edge.
  logic     req_rdy_s;
  logic     cfg_rdy_s;
  logic     res_vld_s;
  fma_res_t res_s;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    req_rdy_s = req.ready;
    cfg_rdy_s = cfg.ready;
    res_vld_s = res.valid;
    res_s     = '{res.sum_bits, res.flag_invalid, res.flag_overflow,
                  res.flag_underflow, res.flag_inexact};
  end

  // --------------------------------------------------------------------------
  // FMA model
  // --------------------------------------------------------------------------
  function automatic bit f_nan(logic [63:0] u);
    return u[62:52] == 11'h7FF && u[51:0] != 0;
  endfunction

  function automatic bit f_inf(logic [63:0] u);
    return u[62:52] == 11'h7FF && u[51:0] == 0;
  endfunction

  function automatic bit f_zero(logic [63:0] u);
    return u[62:0] == 0;
  endfunction

  // finite nonzero value = m * 2^(e-52), m[52] set
  function automatic void split_val(input logic [63:0] u, output logic [52:0] m,
                                    output int e);
    logic [52:0] f;
    f = {1'b0, u[51:0]};
    if (u[62:52] == 0) begin
      e = -1022;
      while (f != 0 && !f[52]) begin
        f = f << 1;
        e--;
      end
      m = f;
    end else begin
      m = {1'b1, u[51:0]};
      e = u[62:52];
      e = e - 1023;
    end
  endfunction

  // right shift that folds the lost bits into a sticky bit
  function automatic void shift_sticky(inout logic [127:0] v, input int s, inout bit st);
    if (s <= 0) return;
    if (s >= 128) begin
      if (v != 0) st = 1'b1;
      v = '0;
    end else begin
      if ((v & ((128'd1 << s) - 128'd1)) != 0) st = 1'b1;
      v = v >> s;
    end
  endfunction

  // x, y finite nonzero; z finite
  function automatic fma_res_t fma_core(logic [63:0] x, logic [63:0] y, logic [63:0] z,
                                        logic [1:0] mode);
    fma_res_t    o;
    logic [52:0] mx, my, mz;
    logic [127:0] w, zw, big, lit, r;
    logic [63:0] m;
    int ex, ey, ez, ep, ea, d, hb, lpos, sb, q, fld;
    bit sp, sz, rs, st, g, inx, up, sbt, tiny, to_inf;
    o = '0;
    mz = '0;
    ez = 0;
    st = 0;
    sbt = 0;
    sp = x[63] ^ y[63];
    sz = z[63];
    split_val(x, mx, ex);
    split_val(y, my, ey);
    if (!f_zero(z)) split_val(z, mz, ez);

    // product with its leading bit at 120
    w = 128'(mx) * 128'(my);
    w = w << 16;
    ep = ex + ey;
    if (w[121]) begin
      w = w >> 1;
      ep++;
    end

    if (mz == 0) begin
      big = w; ea = ep; rs = sp; lit = '0; d = 0;
    end else begin
      zw = 128'(mz) << 68;
      if (ep == ez && w == zw && sp != sz) begin
        o.sum = (mode == RM_RDN) ? SIGN_BIT : 64'd0;
        return o;
      end
      if (ep > ez || (ep == ez && w > zw)) begin
        big = w; ea = ep; rs = sp; lit = zw; d = ep - ez;
      end else begin
        big = zw; ea = ez; rs = sz; lit = w; d = ez - ep;
      end
      sbt = sp != sz;
    end
    shift_sticky(lit, d, st);
    // a sticky remainder on the subtrahend borrows one more unit
    r = sbt ? big - lit - 128'(st) : big + lit;

    hb = 0;
    for (int i = 127; i >= 0; i--) begin
      if (r[i] && hb == 0) hb = i;
    end
    tiny = (ea - 120 + hb) < -1022;
    lpos = hb - 52;
    sb = -1074 - ea + 120;
    if (sb > lpos) lpos = sb;

    if (lpos > 0) begin
      shift_sticky(r, lpos - 1, st);
      g = r[0];
      m = {1'b0, r[63:1]};
    end else begin
      r = r << (-lpos);
      m = r[63:0];
      g = 1'b0;
    end
    q = lpos + ea - 120;

    inx = g | st;
    case (mode)
      RM_RNE:  up = g && (st || m[0]);
      RM_RUP:  up = inx && !rs;
      RM_RDN:  up = inx && rs;
      default: up = 1'b0;
    endcase
    m = m + 64'(up);
    if (m[53]) begin
      m = m >> 1;
      q++;
    end
    fld = m[52] ? q + 1075 : 0;

    o.inx = inx;
    o.unf = inx && tiny;
    if (fld >= 2047) begin
      to_inf = mode == RM_RNE || (mode == RM_RUP && !rs) || (mode == RM_RDN && rs);
      o.ovf = 1'b1;
      o.inx = 1'b1;
      o.sum = {rs, to_inf ? INF_MAG : MAX_MAG};
      return o;
    end
    o.sum = {rs, fld[10:0], m[51:0]};
    return o;
  endfunction

  function automatic fma_res_t fma_predict(logic [63:0] x, logic [63:0] y, logic [63:0] z,
                                           logic [1:0] mode);
    fma_res_t o;
    bit sp;
    o = '0;
    sp = x[63] ^ y[63];
    if (f_nan(x) || f_nan(y) || f_nan(z)) begin
      o.inv = (f_nan(x) && !x[51]) || (f_nan(y) && !y[51]) || (f_nan(z) && !z[51]);
      o.sum = (f_nan(x) ? x : f_nan(y) ? y : z) | QUIET_BIT;
    end else if ((f_inf(x) && f_zero(y)) || (f_zero(x) && f_inf(y))) begin
      o.sum = DEF_NAN;
      o.inv = 1'b1;
    end else if (f_inf(x) || f_inf(y)) begin
      if (f_inf(z) && z[63] != sp) begin
        o.sum = DEF_NAN;
        o.inv = 1'b1;
      end else begin
        o.sum = {sp, INF_MAG};
      end
    end else if (f_inf(z)) begin
      o.sum = z;
    end else if (f_zero(x) || f_zero(y)) begin
      if (!f_zero(z) || z[63] == sp) o.sum = z;
      else o.sum = (mode == RM_RDN) ? SIGN_BIT : 64'd0;
    end else begin
      o = fma_core(x, y, z, mode);
    end
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Operand generation
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_float();
    logic [63:0] r;
    int v;
    r = {$urandom, $urandom};
    v = $urandom_range(99);
    if ($urandom_range(3) == 0) r[40:0] = '0;  // sparse fraction: exact and tie cases
    if (v < 20) return {$urandom, $urandom};
    if (v < 65) r[62:52] = 11'($urandom_range(900, 1150));
    else if (v < 78) r[62:52] = 11'($urandom_range(0, 60));
    else if (v < 88) r[62:52] = 11'($urandom_range(1980, 2046));
    else begin
      case ($urandom_range(7))
        0: r[62:0] = '0;
        1: r[62:0] = INF_MAG;
        2: r[62:0] = {11'h7FF, 1'b0, r[50:0] | 51'd1};      // signaling NaN
        3: r[62:0] = {12'hFFF, r[50:0]};                    // quiet NaN
        4: r[62:0] = 63'd1;
        5: r[62:0] = MAX_MAG;
        6: r[62:52] = '0;
        default: r[62:0] = 63'h3FF0_0000_0000_0000;
      endcase
    end
    return r;
  endfunction

  // Build one triple: mostly an addend in reach of the product so that the
  // add, cancellation and rounding paths get real work.
  task automatic gen_triple(output logic [63:0] a, output logic [63:0] b,
                            output logic [63:0] c);
    fma_res_t t;
    int k, pe;
    k = $urandom_range(99);
    a = rand_float();
    b = rand_float();
    c = rand_float();
    if (k < 45) begin
      pe = int'(a[62:52]) + int'(b[62:52]) - 1023 + $urandom_range(8) - 4;
      if (pe < 0) pe = 0;
      if (pe > 2046) pe = 2046;
      c[62:52] = 11'(pe);
    end else if (k < 55) begin
      // exact product, negated into the addend: full cancellation
      a[62:52] = 11'($urandom_range(800, 1200));
      b[62:52] = 11'($urandom_range(800, 1200));
      a[25:0] = '0;
      b[25:0] = '0;
      t = fma_predict(a, b, 64'd0, RM_RNE);
      if (!t.inx && t.sum[62:52] != 11'h7FF) c = t.sum ^ SIGN_BIT;
    end
  endtask

  // --------------------------------------------------------------------------
  // Request and config drivers
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] c, input fma_res_t want,
                              input bit no_idle);
    while (!no_idle && $urandom_range(99) < 10) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.mult_a <= a;
    req.mult_b <= b;
    req.addend <= c;
    next_sum   <= want;
    @(posedge clk_i);
    while (!req_rdy_s) @(posedge clk_i);
    sent++;
  endtask

  task automatic write_mode(input logic [1:0] mode);
    cfg.valid         <= 1'b1;
    cfg.rounding_mode <= mode;
    @(posedge clk_i);
    while (!cfg_rdy_s) @(posedge clk_i);
    cfg.valid <= 1'b0;
    cur_mode = mode;
  endtask

  // Drop the request valid, wait for every result, then let the pipe empty.
  task automatic drain_pipe();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: queue on request, check on result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fma_res_t want;
    if (rst_ni && req.valid && req_rdy_s) sum_q.push_back(next_sum);
    if (rst_ni && res_vld_s && res.ready) begin
      if (sum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %h", res_s.sum);
      end else begin
        want = sum_q.pop_front();
        if (want !== res_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: sum %h inv %b ovf %b unf %b inx %b, got %h %b %b %b %b",
                     want.sum, want.inv, want.ovf, want.unf, want.inx,
                     res_s.sum, res_s.inv, res_s.ovf, res_s.unf, res_s.inx);
        end
      end
    end
  end

  // Result receiver: random stalls, one long hold-off that fills the pipe,
  // then a long stretch with ready held high.
  initial begin
    int cyc;
    cyc = 0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= 300 && cyc < 500) res.ready <= 1'b0;
      else if (cyc >= 1200 && cyc < 1700) res.ready <= 1'b1;
      else res.ready <= ($urandom_range(99) >= 10);
    end
  end

  // Watchdog: any handshake resets the count.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req_rdy_s) || (res_vld_s && res.ready) || (cfg.valid && cfg_rdy_s))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_MAX) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  vec_t dir_tab[] = '{
    // first NaN wins, quieted; quiet NaN alone raises nothing
    '{64'h7FF8_0000_0000_0001, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1,
      '{64'h7FF8_0000_0000_0001, 1'b0, 1'b0, 1'b0, 1'b0}},
    // signaling NaN ahead of a quiet one
    '{64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 64'hFFF8_0000_0000_0000, 1,
      '{64'h7FF8_0000_0000_0001, 1'b1, 1'b0, 1'b0, 1'b0}},
    // NaN addend beats infinity times zero
    '{64'h0000_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'h7FF0_0000_0000_0001, 1,
      '{64'h7FF8_0000_0000_0001, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1,
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 1'b0}},
    // infinity times zero
    '{64'h7FF0_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1,
      '{DEF_NAN, 1'b1, 1'b0, 1'b0, 1'b0}},
    // opposite infinities
    '{64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1,
      '{DEF_NAN, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{64'hFFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1,
      '{64'hFFF0_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1,
      '{64'h7FF0_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
    // zero product, zeros of opposite sign
    '{64'h0000_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000, 1,
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{64'h0000_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0000, 1,
      '{64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
    // zero product passes a finite addend through
    '{64'h8000_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, 1,
      '{64'h0000_0000_0000_0001, 1'b0, 1'b0, 1'b0, 1'b0}},
    // exact cancellation
    '{64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 1,
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1,
      '{64'h4000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 1'b0}},
    // overflow to infinity
    '{64'h7FEF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 64'h0000_0000_0000_0000, 1,
      '{64'h7FF0_0000_0000_0000, 1'b0, 1'b1, 1'b0, 1'b1}},
    // half the smallest subnormal ties to zero
    '{64'h0000_0000_0000_0001, 64'h3FE0_0000_0000_0000, 64'h0000_0000_0000_0000, 1,
      '{64'h0000_0000_0000_0000, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{64'h7FEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, 0, '0},
    '{64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF, 0, '0},
    '{64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000, 0, '0},
    '{64'h3FF8_0000_0000_0000, 64'h3FF8_0000_0000_0000, 64'h3C30_0000_0000_0000, 0, '0},
    '{64'h0010_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 0, '0},
    '{64'h000F_FFFF_FFFF_FFFF, 64'hC000_0000_0000_0000, 64'h0010_0000_0000_0000, 0, '0},
    '{64'hFFEF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0001, 64'hBFF0_0000_0000_0000, 0, '0},
    '{64'h3FF0_0000_0000_0001, 64'h3FF0_0000_0000_0001, 64'hBFF0_0000_0000_0002, 0, '0}
  };

  logic [1:0] mode_seq[] = '{RM_RDN, RM_RTZ, RM_RUP, RM_RNE, RM_RDN, RM_RUP};

  initial begin
    logic [63:0] a, b, c;
    fma_res_t want;
    int n;
    mismatches = 0;
    sent = 0;
    cur_mode = RM_RNE;
    next_sum = '0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.mult_a = '0;
    req.mult_b = '0;
    req.addend = '0;
    cfg.valid = 1'b0;
    cfg.rounding_mode = RM_RNE;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, nearest-even rounding
    write_mode(RM_RNE);
    foreach (dir_tab[i]) begin
      want = dir_tab[i].fixed ? dir_tab[i].want
                              : fma_predict(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, cur_mode);
      send_request(dir_tab[i].a, dir_tab[i].b, dir_tab[i].c, want, 1'b0);
    end
    drain_pipe();

    // Random phases; the sender pauses for a full drain before each mode change
    n = 0;
    foreach (mode_seq[p]) begin
      write_mode(mode_seq[p]);
      repeat (ITEMS_PHASE) begin
        gen_triple(a, b, c);
        send_request(a, b, c, fma_predict(a, b, c, cur_mode), n >= 700 && n < 1000);
        n++;
      end
      drain_pipe();
    end

    if (mismatches == 0 && sum_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/dfma_pkg.sv
design/dfma_if.sv
design/double_fused_multiply_add_core.sv
bench/tb_top.sv
